// ===== hw/rtl/sfcc_pkg.sv =====
// Package with the widths, codes and CRC function of the sensor frame CRC check.
package sfcc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 3;

  // Output tdata: temperature, humidity, status, padded to whole bytes.
  localparam int unsigned OutFieldsW = 2 * WordW + StatusW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] CrcPoly  = 8'h31;
  localparam logic [ByteW-1:0] CrcInit  = 8'hFF;
  localparam logic [WordW-1:0] WordInit = 16'hFFFF;

  localparam logic [PosW-1:0] PosTempHi  = 3'd0;
  localparam logic [PosW-1:0] PosTempLo  = 3'd1;
  localparam logic [PosW-1:0] PosTempCrc = 3'd2;
  localparam logic [PosW-1:0] PosHumHi   = 3'd3;
  localparam logic [PosW-1:0] PosHumLo   = 3'd4;
  localparam logic [PosW-1:0] PosHumCrc  = 3'd5;
  localparam logic [PosW-1:0] PosFull    = 3'd6;
  localparam logic [PosW-1:0] PosMax     = 3'd7;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_COUNT = 2'd1,
    STATUS_CRC   = 2'd2
  } status_t;

  // One byte of CRC-8, MSB first, unrolled over the eight bits.
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                    input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < ByteW; i++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/sensor_frame_crc_check_top.sv =====
// Sensor frame CRC check: frame tracking, CRC and word store with an output register.
//
// The block takes a six-byte sensor reply one byte per transfer: a big-endian
// temperature word and its CRC-8 byte, then a humidity word and its CRC-8 byte
// (polynomial 0x31, initial value 0xFF, no final XOR). s_tuser marks the first
// byte of a reply and s_tlast its final byte; after a final byte the next byte
// starts a new reply even without the start mark. Each transfer with s_tlast
// yields one result transfer holding the stored words and a status (ok, wrong
// byte count, CRC error); only a good reply replaces the stored words, which
// come out of reset as 0xFFFF. One byte is taken in every cycle: the CRC update
// and framing logic are combinational and load the state registers directly, and the single
// output register stalls the input only while a result is held and not taken.
module sensor_frame_crc_check_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [sfcc_pkg::ByteW-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                          s_tuser,   // [0] frame_start
  input  logic                          s_tlast,   // frame_end
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sfcc_pkg::OutDataW-1:0] m_tdata    // [15:0] temperature_raw,
                                                   // [31:16] humidity_raw,
                                                   // [33:32] status, rest zero
);
  import sfcc_pkg::*;

  logic [PosW-1:0]  byte_position, byte_position_next;
  logic [ByteW-1:0] crc_register, crc_register_next;
  logic             check_failed, check_failed_next;
  logic [WordW-1:0] word_assembly, word_assembly_next;
  logic [WordW-1:0] pending_temperature, pending_temperature_next;
  logic [WordW-1:0] stored_temperature, stored_temperature_next;
  logic [WordW-1:0] stored_humidity, stored_humidity_next;
  status_t          status_next;

  logic [PosW-1:0]  pos_cur;
  logic [ByteW-1:0] crc_cur;
  logic             fail_cur;
  logic [ByteW-1:0] crc_byte;
  logic             s_accept;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  // A start mark clears the framing state before its own byte is taken.
  assign pos_cur  = s_tuser ? PosTempHi : byte_position;
  assign crc_cur  = s_tuser ? CrcInit : crc_register;
  assign fail_cur = s_tuser ? 1'b0 : check_failed;
  assign crc_byte = crc8_update(crc_cur, s_tdata);

  always_comb begin
    byte_position_next       = pos_cur;
    crc_register_next        = crc_cur;
    check_failed_next        = fail_cur;
    word_assembly_next       = word_assembly;
    pending_temperature_next = pending_temperature;
    stored_temperature_next  = stored_temperature;
    stored_humidity_next     = stored_humidity;
    status_next              = STATUS_OK;

    unique case (pos_cur)
      PosTempHi, PosHumHi: begin
        word_assembly_next = {s_tdata, {ByteW{1'b0}}};
        crc_register_next  = crc_byte;
      end
      PosTempLo, PosHumLo: begin
        word_assembly_next = {word_assembly[WordW-1 -: ByteW], s_tdata};
        crc_register_next  = crc_byte;
      end
      PosTempCrc: begin
        check_failed_next        = fail_cur || (s_tdata != crc_cur);
        pending_temperature_next = word_assembly;
        crc_register_next        = CrcInit;
      end
      PosHumCrc: begin
        check_failed_next = fail_cur || (s_tdata != crc_cur);
      end
      default: begin
      end
    endcase

    // The count saturates: seven means seven or more bytes.
    if (pos_cur != PosMax) begin
      byte_position_next = pos_cur + 1'b1;
    end

    if (s_tlast) begin
      priority if (byte_position_next != PosFull) begin
        status_next = STATUS_COUNT;
      end else if (check_failed_next) begin
        status_next = STATUS_CRC;
      end else begin
        status_next             = STATUS_OK;
        stored_temperature_next = pending_temperature_next;
        stored_humidity_next    = word_assembly_next;
      end
      byte_position_next = PosTempHi;
      crc_register_next  = CrcInit;
      check_failed_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= PosTempHi;
      crc_register       <= CrcInit;
      check_failed       <= 1'b0;
      stored_temperature <= WordInit;
      stored_humidity    <= WordInit;
    end else if (s_accept) begin
      byte_position      <= byte_position_next;
      crc_register       <= crc_register_next;
      check_failed       <= check_failed_next;
      stored_temperature <= stored_temperature_next;
      stored_humidity    <= stored_humidity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      word_assembly       <= word_assembly_next;
      pending_temperature <= pending_temperature_next;
    end
  end

  // Output register; it loads only on the final byte of a reply.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && s_tlast) begin
      m_tdata <= {{(OutDataW - OutFieldsW){1'b0}}, status_next,
                  stored_humidity_next, stored_temperature_next};
    end
  end

  // A final byte always leaves the framing state cleared.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tlast) |=> (byte_position == PosTempHi && crc_register == CrcInit
                               && !check_failed))
    else $error("framing state not cleared after final byte");

  // A held result always shows the words currently stored.
  a_result_matches_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[WordW-1:0] == stored_temperature
                  && m_tdata[2*WordW-1:WordW] == stored_humidity))
    else $error("result words differ from stored words");

  // Stored words change only on a final byte that reports ok.
  a_store_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    !(s_accept && s_tlast && status_next == STATUS_OK)
      |=> ($stable(stored_temperature) && $stable(stored_humidity)))
    else $error("stored words changed without a good reply");

  // Every final byte produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_tlast) |=> m_tvalid)
    else $error("final byte produced no result");

endmodule

// ===== tb/sv/sensor_frame_crc_check_top_test.sv =====
// Testbench for the sensor frame CRC check: directed and random replies, scoreboard with predictor.
`timescale 1ns / 100ps

module sensor_frame_crc_check_top_test;
  import sfcc_pkg::*;

  localparam int unsigned RandomBytes = 700;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;

  typedef struct packed {
    logic [WordW-1:0] temperature;
    logic [WordW-1:0] humidity;
    status_t          status;
  } reading_t;

  // Tracks the reply framing and the stored words, and holds the readings still due.
  class reading_checker;
    reading_t         expected_readings[$];
    int unsigned      mismatches;
    logic [PosW-1:0]  pos;
    logic [ByteW-1:0] crc;
    logic [WordW-1:0] word;
    logic [WordW-1:0] temp_pending;
    logic [WordW-1:0] temp_kept;
    logic [WordW-1:0] hum_kept;
    bit               crc_bad;

    function new();
      restart();
      word         = '0;
      temp_pending = '0;
      temp_kept    = WordInit;
      hum_kept     = WordInit;
      mismatches   = 0;
    endfunction

    static function logic [ByteW-1:0] crc8_step(logic [ByteW-1:0] c, logic [ByteW-1:0] b);
      logic [ByteW-1:0] r;
      logic             top;
      r = c ^ b;
      repeat (ByteW) begin
        top = r[ByteW-1];
        r   = r << 1;
        if (top) begin
          r = r ^ CrcPoly;
        end
      end
      return r;
    endfunction

    static function logic [ByteW-1:0] word_crc(logic [WordW-1:0] w);
      return crc8_step(crc8_step(CrcInit, w[15:8]), w[7:0]);
    endfunction

    function void restart();
      pos     = PosTempHi;
      crc     = CrcInit;
      crc_bad = 1'b0;
    endfunction

    // Called for every accepted input transfer.
    function void take_byte(logic [ByteW-1:0] b, logic first, logic last);
      reading_t r;
      if (first) begin
        restart();
      end
      case (pos)
        PosTempHi, PosHumHi: begin
          word = {b, 8'h00};
          crc  = crc8_step(crc, b);
        end
        PosTempLo, PosHumLo: begin
          word[7:0] = b;
          crc       = crc8_step(crc, b);
        end
        PosTempCrc: begin
          if (b != crc) begin
            crc_bad = 1'b1;
          end
          temp_pending = word;
          crc          = CrcInit;
        end
        PosHumCrc: begin
          if (b != crc) begin
            crc_bad = 1'b1;
          end
        end
        default: ;
      endcase
      if (pos != PosMax) begin
        pos = pos + 1'b1;
      end
      if (!last) begin
        return;
      end
      // A wrong byte count wins over a CRC error; only a clean reply updates the words.
      if (pos != PosFull) begin
        r.status = STATUS_COUNT;
      end else if (crc_bad) begin
        r.status = STATUS_CRC;
      end else begin
        r.status  = STATUS_OK;
        temp_kept = temp_pending;
        hum_kept  = word;
      end
      restart();
      r.temperature = temp_kept;
      r.humidity    = hum_kept;
      expected_readings.push_back(r);
    endfunction

    function void note_mismatch(string field, logic [WordW-1:0] want, logic [WordW-1:0] got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s: expected %h, got %h", field, want, got);
      end
    endfunction

    // Called for every accepted output transfer.
    function void check_reading(logic [OutDataW-1:0] d);
      reading_t e;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transfer: %h", d);
        end
        return;
      end
      e = expected_readings.pop_front();
      if (d[15:0] != e.temperature) begin
        note_mismatch("temperature_raw", e.temperature, d[15:0]);
      end
      if (d[31:16] != e.humidity) begin
        note_mismatch("humidity_raw", e.humidity, d[31:16]);
      end
      if (d[33:32] != e.status) begin
        note_mismatch("status", {14'd0, e.status}, {14'd0, d[33:32]});
      end
    endfunction

    function int unsigned outstanding();
      return expected_readings.size();
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  reading_checker sb = new();
  int unsigned    src_idle_pct   = 0;
  int unsigned    sink_stall_pct = 0;
  int unsigned    sent           = 0;
  int unsigned    cycles         = 0;

  sensor_frame_crc_check_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.take_byte(s_tdata, s_tuser, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        sb.check_reading(m_tdata);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic first, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Sends n bytes of a reply; spoil[0] and spoil[1] corrupt the two CRC bytes.
  task automatic send_reply(input logic [WordW-1:0] t, input logic [WordW-1:0] h,
                            input logic mark, input logic [1:0] spoil, input int unsigned n);
    logic [ByteW-1:0] frame [0:11];
    frame[0] = t[15:8];
    frame[1] = t[7:0];
    frame[2] = reading_checker::word_crc(t) ^ (spoil[0] ? 8'($urandom_range(1, 255)) : 8'h00);
    frame[3] = h[15:8];
    frame[4] = h[7:0];
    frame[5] = reading_checker::word_crc(h) ^ (spoil[1] ? 8'($urandom_range(1, 255)) : 8'h00);
    for (int i = 6; i < 12; i++) begin
      frame[i] = 8'($urandom_range(0, 255));
    end
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(frame[i], mark && (i == 0), i == n - 1);
    end
  endtask

  task automatic random_reply();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    n    = $urandom_range(1, 9);
    if (n >= 6) begin
      n++;
    end
    if (pick < 55) begin
      send_reply(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                 1'($urandom_range(0, 1)), 2'b00, 6);
    end else if (pick < 75) begin
      send_reply(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                 1'($urandom_range(0, 1)), 2'($urandom_range(1, 3)), 6);
    end else if (pick < 90) begin
      send_reply(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), n);
    end else begin
      // Loose bytes with random start and end marks.
      repeat ($urandom_range(1, 8)) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                  $urandom_range(0, 4) == 0);
      end
    end
  endtask

  // Holds the sender off until every expected result has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned base;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct   = 8;
    sink_stall_pct = 45;

    // A lone byte with both marks, then the word extremes in clean and damaged replies.
    send_reply(16'hFF00, 16'h0000, 1'b1, 2'b00, 1);
    send_reply(16'h0000, 16'hFFFF, 1'b1, 2'b00, 6);
    send_reply(16'hFFFF, 16'h0000, 1'b0, 2'b10, 6);
    // A start mark in the middle of a reply restarts it.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_reply(16'hFFFF, 16'h0000, 1'b1, 2'b00, 6);
    // Seven bytes: too long, whatever the CRC bytes say.
    send_reply(16'h1234, 16'h5678, 1'b1, 2'b00, 7);
    wait_drained();

    base = sent;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 8;
          sink_stall_pct = 45;
        end
        1: begin
          src_idle_pct   = 45;
          sink_stall_pct = 8;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      while (sent < base + RandomBytes * (ph + 1) / 3) begin
        random_reply();
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (sb.outstanding() != 0) begin
      $display("results still missing: %0d", sb.outstanding());
    end
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
